// ===== hdl/median_then_smooth_position_macros.svh =====
// Assertion macros for the position filter.
`ifndef MEDIAN_THEN_SMOOTH_POSITION_MACROS_SVH
`define MEDIAN_THEN_SMOOTH_POSITION_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define MTSP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");
// Next-cycle implication, checked outside reset.
`define MTSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");
`else
`define MTSP_ASSERT_NOW(label, clk, rst, ante, cons)
`define MTSP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/mtsp_pkg.sv =====
`timescale 1ns / 1ps
package mtsp_pkg;

   // Ages run to WINDOW-1; WINDOW stays at or below 32.
   localparam int AGE_BITS = 5;
   localparam int POS_BITS = 16;
   localparam logic [POS_BITS-1:0] SMOOTH_RESET = 16'd6400;

   typedef struct packed {
      logic                valid;
      logic [AGE_BITS-1:0] age;
      logic [POS_BITS-1:0] value;
   } cell_type;

   // What a cell hands to its upper neighbor: its post-removal content and
   // whether that content sorts above the incoming sample.
   typedef struct packed {
      cell_type c;
      logic     gt;
   } link_type;

endpackage

// ===== hdl/mtsp_cell.sv =====
`timescale 1ns / 1ps
module mtsp_cell
   import mtsp_pkg::*;
#(
   parameter logic [AGE_BITS-1:0] LAST_AGE = 5'd6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                full,
   input  logic [POS_BITS-1:0] sample,
   input  link_type            prev_link,
   input  logic                prev_del,
   input  cell_type            next_cell,
   output cell_type            held,
   output link_type            link,
   output logic                del_upto
);

   cell_type cell_ff;
   cell_type cell_in;
   cell_type comp;
   logic     del_here;

   always_comb begin
      del_here = full && cell_ff.valid && (cell_ff.age == LAST_AGE);
      del_upto = prev_del || del_here;
      // Close the gap left by the dropped oldest item.
      comp     = del_upto ? next_cell : cell_ff;
      link.c   = comp;
      link.gt  = !comp.valid || (comp.value > sample);
      if (!link.gt) begin
         cell_in     = comp;
         cell_in.age = comp.age + AGE_BITS'(1);
      end else if (prev_link.gt) begin
         cell_in     = prev_link.c;
         cell_in.age = prev_link.c.age + AGE_BITS'(1);
      end else begin
         cell_in.valid = 1'b1;
         cell_in.age   = '0;
         cell_in.value = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (step) begin
         cell_ff <= cell_in;
      end
   end

   assign held = cell_ff;

endmodule

// ===== hdl/median_then_smooth_position.sv =====
`timescale 1ns / 1ps
// Running median of the last WINDOW x-position samples followed by a 3/4 step
// of the smoothed position toward that median. Takes one item per cycle
// while rsp_ready stays high. The accepting edge updates the sorted cell chain
// (drop the oldest sample, insert the new one); a later edge, once the result
// register is free, picks the median cell, blends and registers the result
// and raises rsp_valid. The smoothed position starts at 400 px (Q12.4) after
// reset; req_ready drops only while a result waits on rsp and another item is
// already in the chain.
`include "median_then_smooth_position_macros.svh"
module median_then_smooth_position
   import mtsp_pkg::*;
#(
   parameter int WINDOW = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [POS_BITS-1:0] req_sample_x,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [POS_BITS-1:0] rsp_smoothed_x,
   output logic [POS_BITS-1:0] rsp_median_x
);

   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   cell_type   cells [0:WINDOW];
   link_type   links [0:WINDOW];
   logic       dels  [0:WINDOW];

   logic [CNT_W-1:0]    count_ff;
   logic                pend_ff;
   logic                out_valid_ff;
   logic [POS_BITS-1:0] smooth_ff;
   logic [POS_BITS-1:0] out_smooth_ff;
   logic [POS_BITS-1:0] out_median_ff;

   logic                step;
   logic                full;
   logic                fire_b;
   logic [IDX_W-1:0]    mid;
   logic [POS_BITS-1:0] median;
   logic [POS_BITS+1:0] blend_in;

   assign full      = (count_ff == CNT_W'(WINDOW));
   assign fire_b    = pend_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !pend_ff || fire_b;
   assign step      = req_valid && req_ready;

   assign cells[WINDOW] = '0;
   assign links[0]      = '0;
   assign dels[0]       = 1'b0;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      mtsp_cell #(
         .LAST_AGE(AGE_BITS'(WINDOW - 1))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (step),
         .full     (full),
         .sample   (req_sample_x),
         .prev_link(links[i]),
         .prev_del (dels[i]),
         .next_cell(cells[i+1]),
         .held     (cells[i]),
         .link     (links[i+1]),
         .del_upto (dels[i+1])
      );
   end

   // Upper median: sorted position count/2.
   always_comb begin
      mid      = IDX_W'(count_ff >> 1);
      median   = cells[mid].value;
      blend_in = ({2'b00, smooth_ff} + {2'b00, median} + {1'b0, median, 1'b0}) >> 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         smooth_ff    <= SMOOTH_RESET;
      end else begin
         if (step && !full) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (step) begin
            pend_ff <= 1'b1;
         end else if (fire_b) begin
            pend_ff <= 1'b0;
         end
         if (fire_b) begin
            out_valid_ff  <= 1'b1;
            smooth_ff     <= blend_in[POS_BITS-1:0];
            out_smooth_ff <= blend_in[POS_BITS-1:0];
            out_median_ff <= median;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_smoothed_x = out_smooth_ff;
   assign rsp_median_x   = out_median_ff;

   `MTSP_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(WINDOW))
   `MTSP_ASSERT_NOW(a_full_drops_one, clock, reset, step && full, dels[WINDOW] && !links[WINDOW].c.valid)
   `MTSP_ASSERT_NOW(a_low_cell_valid, clock, reset, count_ff != '0, cells[0].valid)
   `MTSP_ASSERT_NEXT(a_accept_pends, clock, reset, step, pend_ff)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb
   import mtsp_pkg::*;
();

   localparam int DEPTH = 7;
   localparam int RANDOM_ITEMS = 1400;
   localparam int CYCLE_LIMIT = 400000;
   localparam int NUM_ROWS = 22;

   typedef struct packed {
      logic [POS_BITS-1:0] sample;
      logic                typed;
      logic [POS_BITS-1:0] smoothed;
      logic [POS_BITS-1:0] median;
   } stim_row_type;

   typedef struct packed {
      logic [POS_BITS-1:0] smoothed;
      logic [POS_BITS-1:0] median;
   } position_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [POS_BITS-1:0] req_sample_x;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [POS_BITS-1:0] rsp_smoothed_x;
   logic [POS_BITS-1:0] rsp_median_x;

   // filter state as the block should hold it
   logic [POS_BITS-1:0] window_hist [0:DEPTH-1];
   int                  held_count;
   int                  next_slot;
   logic [POS_BITS-1:0] smooth_pos;

   position_type        pending_positions [$];
   stim_row_type        directed_rows [0:NUM_ROWS-1];
   int                  error_count = 0;
   int                  cycle_count = 0;
   bit                  steady;
   logic [POS_BITS-1:0] walk_pos;

   median_then_smooth_position #(.WINDOW(DEPTH)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_x   (req_sample_x),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_smoothed_x (rsp_smoothed_x),
      .rsp_median_x   (rsp_median_x)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Push a sample into the window, take the upper median, blend 3/4 toward it.
   function automatic position_type filter_step(input logic [POS_BITS-1:0] x);
      logic [POS_BITS-1:0] sorted [0:DEPTH-1];
      logic [POS_BITS-1:0] key;
      logic [POS_BITS+1:0] blend;
      position_type        res;
      int                  i;
      int                  j;
      window_hist[next_slot] = x;
      next_slot = (next_slot + 1 >= DEPTH) ? 0 : next_slot + 1;
      if (held_count < DEPTH)
         held_count++;
      for (i = 0; i < held_count; i++) begin
         key = window_hist[i];
         j = i;
         while (j > 0 && sorted[j-1] > key) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = key;
      end
      res.median = sorted[held_count / 2];
      blend = {2'b00, smooth_pos} + 18'(res.median) * 18'd3;
      smooth_pos = blend[POS_BITS+1:2];
      res.smoothed = smooth_pos;
      return res;
   endfunction

   function automatic logic [POS_BITS-1:0] random_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return POS_BITS'($urandom);
      end else if (r < 75) begin
         // clustered values give ties and near ties in the window
         return POS_BITS'(16'h4000 + $urandom_range(0, 3) * 16);
      end else if (r < 85) begin
         return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      end else begin
         // slow track with occasional outliers in between
         walk_pos = walk_pos + POS_BITS'($urandom_range(0, 64)) - 16'd32;
         return walk_pos;
      end
   endfunction

   // Present one item and hold it until accepted; expectation is queued at
   // the accepting edge.
   task automatic send_sample(input logic [POS_BITS-1:0] x, input bit typed,
                              input position_type typed_res);
      int           gap;
      position_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_x <= x;
      do @(posedge clock); while (!req_ready);
      res = filter_step(x);
      pending_positions.insert(pending_positions.size(), typed ? typed_res : res);
   endtask

   // result side: check accepted items and stall at random
   initial begin : rsp_side
      int           stall;
      position_type want;
      stall = 0;
      @(posedge clock);
      forever begin
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_positions.size() == 0) begin
               $display("%0t: unexpected item smoothed_x=%0d median_x=%0d",
                        $time, rsp_smoothed_x, rsp_median_x);
               error_count++;
            end else begin
               want = pending_positions.pop_front();
               if (rsp_smoothed_x !== want.smoothed) begin
                  $display("%0t: smoothed_x expected %0d actual %0d",
                           $time, want.smoothed, rsp_smoothed_x);
                  error_count++;
               end
               if (rsp_median_x !== want.median) begin
                  $display("%0t: median_x expected %0d actual %0d",
                           $time, want.median, rsp_median_x);
                  error_count++;
               end
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            stall = pick_gap();
            rsp_ready <= (stall == 0);
         end
         @(posedge clock);
      end
   end

   initial begin : req_side
      position_type typed_res;
      int           n;
      int           guard;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_x = '0;
      rsp_ready = 1'b0;
      steady = 1'b0;
      walk_pos = 16'd6400;
      held_count = 0;
      next_slot = 0;
      smooth_pos = SMOOTH_RESET;
      for (n = 0; n < DEPTH; n++)
         window_hist[n] = '0;

      // typed rows: first item, extremes, upper median of an even count
      directed_rows = '{
         '{16'd0,     1'b1, 16'd1600,  16'd0},
         '{16'd65535, 1'b1, 16'd49551, 16'd65535},
         '{16'd65535, 1'b1, 16'd61539, 16'd65535},
         '{16'd0,     1'b1, 16'd64536, 16'd65535},
         '{16'd32768, 1'b0, 16'd0, 16'd0},
         '{16'd1,     1'b0, 16'd0, 16'd0},
         '{16'd65534, 1'b0, 16'd0, 16'd0},
         '{16'h5555,  1'b0, 16'd0, 16'd0},
         '{16'hAAAA,  1'b0, 16'd0, 16'd0},
         '{16'h00FF,  1'b0, 16'd0, 16'd0},
         '{16'hFF00,  1'b0, 16'd0, 16'd0},
         '{16'd1234,  1'b0, 16'd0, 16'd0},
         '{16'd1234,  1'b0, 16'd0, 16'd0},
         '{16'd1234,  1'b0, 16'd0, 16'd0},
         '{16'd1234,  1'b0, 16'd0, 16'd0},
         '{16'd6400,  1'b0, 16'd0, 16'd0},
         '{16'd0,     1'b0, 16'd0, 16'd0},
         '{16'd65535, 1'b0, 16'd0, 16'd0},
         '{16'd0,     1'b0, 16'd0, 16'd0},
         '{16'd65535, 1'b0, 16'd0, 16'd0},
         '{16'h8000,  1'b0, 16'd0, 16'd0},
         '{16'h7FFF,  1'b0, 16'd0, 16'd0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < NUM_ROWS; n++) begin
         typed_res.smoothed = directed_rows[n].smoothed;
         typed_res.median = directed_rows[n].median;
         send_sample(directed_rows[n].sample, directed_rows[n].typed, typed_res);
      end

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // alternate stretches with and without idling
         if (n % 100 == 0)
            steady = ($urandom_range(0, 3) == 0);
         send_sample(random_sample(), 1'b0, typed_res);
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      guard = 0;
      while (pending_positions.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_positions.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
